// File: rtl/core/hwsf_pkg.sv
// ----------------------------------------------------------------------------
// hwsf_pkg
// Shared types, constants and Q30 arithmetic for the windowed sinc FIR
// coefficient generator.
// ----------------------------------------------------------------------------
package hwsf_pkg;

  localparam int MAX_TAPS       = 1024;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = 18;
  localparam int TAP_W          = 10;
  localparam int LEN_W          = 11;
  localparam int FC_W           = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int PHASE_W        = 20;
  localparam int MP_W           = 26;
  localparam int REM_W          = 44;
  localparam int QUO_W          = 31;
  localparam int PROD_W         = 62;
  localparam int SHIFT          = 60 - COEF_FRAC_BITS;
  localparam int MAG_W          = PROD_W - SHIFT;
  localparam int SINC_STEPS     = 31;
  localparam int WIN_STEPS      = 20;
  localparam int HORNER_STEPS   = 5;
  localparam int DEPTH          = 44;

  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;

  localparam logic [FC_W-1:0]    CUTOFF_RESET = 16'd16384;
  localparam logic [LEN_W-1:0]   LENGTH_RESET = 11'd64;
  localparam logic [31:0]        PI_Q30       = 32'd3373259426;
  localparam logic [QUO_W-1:0]   ONE_Q30      = 31'h4000_0000;
  localparam logic [PHASE_W-1:0] QUARTER      = 20'h40000;
  localparam logic [COEF_W-1:0]  COEF_MAX_POS = 18'd131071;
  localparam logic [COEF_W-1:0]  COEF_MAX_NEG = 18'd131072;

  typedef logic signed [31:0] q30_t;

  localparam q30_t SIN_POLY [HORNER_STEPS+1] = '{
    -32'sd3864, 32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668,
    32'sd1686629713
  };

  typedef struct packed {
    q30_t       acc;
    q30_t       s;
    q30_t       u;
    logic [1:0] quad;
  } sin_st_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [TAP_W-1:0] tap;
    logic             err;
    logic             len1;
    logic             zero;
    logic             negp;
    logic             ovf;
    logic             negs;
  } side_t;

  function automatic q30_t mul_q30(q30_t a, q30_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [31:0] m;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    pr = 64'(ma) * 64'(mb);
    m  = pr[61:30];
    return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: rtl/core/hwsf_horner_cell.sv
// ----------------------------------------------------------------------------
// hwsf_horner_cell
// One Horner step of the sine polynomial: acc = coef + acc * s.
// ----------------------------------------------------------------------------
module hwsf_horner_cell import hwsf_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  q30_t    coef_i,
  input  sin_st_t stage_i,
  output sin_st_t stage_o
);

  sin_st_t stage_d, stage_q;

  always_comb begin
    stage_d     = stage_i;
    stage_d.acc = coef_i + mul_q30(stage_i.acc, stage_i.s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// File: rtl/core/hwsf_div_cell.sv
// ----------------------------------------------------------------------------
// hwsf_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module hwsf_div_cell import hwsf_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t           div_d, div_q;
  logic [REM_W:0] rem2;

  always_comb begin
    div_d = div_i;
    rem2  = {div_i.rem, 1'b0};
    if (rem2 >= {1'b0, div_i.den}) begin
      div_d.rem = REM_W'(rem2 - {1'b0, div_i.den});
      div_d.quo = {div_i.quo[QUO_W-2:0], 1'b1};
    end else begin
      div_d.rem = rem2[REM_W-1:0];
      div_d.quo = {div_i.quo[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// File: rtl/core/hwsf_sine.sv
// ----------------------------------------------------------------------------
// hwsf_sine
// Pipelined Q30 sine of a 20-bit phase: fold, square, Horner row, scale.
// ----------------------------------------------------------------------------
module hwsf_sine import hwsf_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [PHASE_W-1:0] phase_i,
  output q30_t               value_o
);

  logic [1:0] quad;
  logic [18:0] r19;
  logic [1:0] quad_q;
  q30_t       u_q;
  sin_st_t    first_d, first_q;
  sin_st_t    chain [HORNER_STEPS+1];
  q30_t       v, v_d, v_q;

  always_comb begin
    quad = phase_i[19:18];
    r19  = {1'b0, phase_i[17:0]};
    if (quad[0]) begin
      r19 = QUARTER[18:0] - {1'b0, phase_i[17:0]};
    end
  end

  always_comb begin
    first_d.acc  = SIN_POLY[0];
    first_d.s    = mul_q30(u_q, u_q);
    first_d.u    = u_q;
    first_d.quad = quad_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q  <= quad;
      u_q     <= $signed({1'b0, r19, 12'b0});
      first_q <= first_d;
      v_q     <= v_d;
    end
  end

  assign chain[0] = first_q;

  for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
    hwsf_horner_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .coef_i  (SIN_POLY[k]),
      .stage_i (chain[k-1]),
      .stage_o (chain[k])
    );
  end

  always_comb begin
    v = mul_q30(chain[HORNER_STEPS].acc, chain[HORNER_STEPS].u);
    if (v < 0) begin
      v = '0;
    end
    if (v > $signed({1'b0, ONE_Q30})) begin
      v = $signed({1'b0, ONE_Q30});
    end
    v_d = chain[HORNER_STEPS].quad[1] ? -v : v;
  end

  assign value_o = v_q;

endmodule

// File: rtl/core/hann_windowed_sinc_fir_coefficient.sv
// ----------------------------------------------------------------------------
// hann_windowed_sinc_fir_coefficient
// Hann-windowed sinc low-pass FIR coefficient generator.
//
// Items arrive on the in channel (in_valid_i, in_stall_o, tap_index_i) and
// each gives one result on the out channel (out_valid_o, out_stall_i,
// coefficient_o, tap_index_echo_o, index_error_o), in order.
// Cutoff (register 0) and length (register 1) are written over the cfg
// channel, which is always ready; write only while no item is in flight.
// One item is taken every cycle while no result is stalled: the sinc
// quotient runs through a row of 31 division cells, the window phase through
// 20, and each sine through a five-cell Horner row, all advancing together.
// Reset clears the valid pipeline and loads cutoff 16384 and length 64.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised; bubbles are not squeezed out.
// ----------------------------------------------------------------------------
module hann_windowed_sinc_fir_coefficient import hwsf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TAP_W-1:0]         tap_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COEF_W-1:0] coefficient_o,
  output logic [TAP_W-1:0]         tap_index_echo_o,
  output logic                     index_error_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  logic              en;
  logic [FC_W-1:0]   cutoff_q;
  logic [LEN_W-1:0]  length_q;

  logic              vld_q [DEPTH+1];
  side_t             side_d [DEPTH];
  side_t             side_q [DEPTH];

  logic [LEN_W-1:0]  len_eff;
  logic [TAP_W-1:0]  tap1;
  logic [TAP_W-1:0]  dv;
  logic [TAP_W-1:0]  rw;
  logic signed [12:0] d2;
  logic signed [29:0] p1;
  logic [29:0]       pabs;
  logic [MP_W-1:0]   mp_d, mp_q;
  logic [PHASE_W-1:0] ph_d, ph_q;
  div_t              win_init_d, win_init_q;

  logic [57:0]       den_prod;
  logic [REM_W-1:0]  den_q [2:9];

  q30_t              sin_a;
  logic [QUO_W-1:0]  sabs;
  logic [31:0]       rem2x;
  logic              ovf;
  div_t              sinc_init_d, sinc_init_q;
  div_t              sc [SINC_STEPS+1];
  div_t              wc [WIN_STEPS+1];

  logic [PHASE_W-1:0] cos_ph;
  q30_t              cos_v;
  logic signed [32:0] wdiff;
  logic [QUO_W-1:0]  w_d30;
  logic [QUO_W-1:0]  w_q [30:42];
  logic [QUO_W-1:0]  mag_d, mag_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] rnd;
  logic [MAG_W-1:0]  magc;
  logic [MAG_W-1:0]  mags;
  logic [COEF_W-1:0] coef_d, coef_q;
  logic [TAP_W-1:0]  echo_q;
  logic              err_q;

  assign en          = !(vld_q[DEPTH] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
      length_q <= LENGTH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CUTOFF: cutoff_q <= cfg_data_i[FC_W-1:0];
        REG_LENGTH: length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = (length_q > LEN_W'(MAX_TAPS)) ? LEN_W'(MAX_TAPS) : length_q;
    tap1    = side_q[0].tap;
    d2      = $signed({2'b00, tap1, 1'b0}) - $signed({2'b00, len_eff}) + 13'sd1;
    p1      = 30'($signed({1'b0, cutoff_q})) * 30'(d2);
    pabs    = p1[29] ? 30'(-p1) : 30'(p1);
    mp_d    = pabs[MP_W-1:0];
    ph_d    = {p1[16:0], 3'b000};
    dv      = TAP_W'(len_eff - LEN_W'(1));
    rw      = (tap1 >= dv) ? tap1 - dv : tap1;
    win_init_d.rem = REM_W'(rw);
    win_init_d.den = REM_W'(dv);
    win_init_d.quo = '0;
  end

  always_comb begin
    sabs  = sin_a[31] ? QUO_W'(-sin_a) : QUO_W'(sin_a);
    rem2x = {sabs, 1'b0};
    ovf   = REM_W'(rem2x) >= den_q[9];
    sinc_init_d.rem = REM_W'(rem2x);
    sinc_init_d.den = den_q[9];
    sinc_init_d.quo = '0;
  end

  always_comb begin
    side_d[0]     = '0;
    side_d[0].tap = tap_index_i;
    for (int k = 1; k < DEPTH; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[1].err  = {1'b0, tap1} >= len_eff;
    side_d[1].len1 = len_eff == LEN_W'(1);
    side_d[1].zero = p1 == '0;
    side_d[1].negp = p1[29];
    side_d[10].ovf  = ovf;
    side_d[10].negs = sin_a[31] ^ side_q[9].negp;
  end

  assign den_prod = 58'(mp_q) * 58'(PI_Q30);

  always_comb begin
    cos_ph = wc[WIN_STEPS].quo[PHASE_W-1:0] + QUARTER;
    wdiff  = $signed({2'b00, ONE_Q30}) - 33'(cos_v);
    w_d30  = side_q[29].len1 ? ONE_Q30 : wdiff[31:1];
    if (side_q[41].zero || side_q[41].ovf || sc[SINC_STEPS].quo > ONE_Q30) begin
      mag_d = ONE_Q30;
    end else begin
      mag_d = sc[SINC_STEPS].quo;
    end
  end

  always_comb begin
    rnd  = prod_q + (PROD_W'(1) << (SHIFT - 1));
    magc = rnd[PROD_W-1:SHIFT];
    if (side_q[DEPTH-1].negs) begin
      mags   = (magc > MAG_W'(COEF_MAX_NEG)) ? MAG_W'(COEF_MAX_NEG) : magc;
      coef_d = COEF_W'(-mags);
    end else begin
      mags   = (magc > MAG_W'(COEF_MAX_POS)) ? MAG_W'(COEF_MAX_POS) : magc;
      coef_d = COEF_W'(mags);
    end
    if (side_q[DEPTH-1].err) begin
      coef_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DEPTH; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k <= DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < DEPTH; k++) begin
        side_q[k] <= side_d[k];
      end
      mp_q        <= mp_d;
      ph_q        <= ph_d;
      win_init_q  <= win_init_d;
      den_q[2]    <= den_prod[57:14];
      for (int k = 3; k <= 9; k++) begin
        den_q[k] <= den_q[k-1];
      end
      sinc_init_q <= sinc_init_d;
      w_q[30]     <= w_d30;
      for (int k = 31; k <= 42; k++) begin
        w_q[k] <= w_q[k-1];
      end
      mag_q       <= mag_d;
      prod_q      <= PROD_W'(mag_q) * PROD_W'(w_q[42]);
      coef_q      <= coef_d;
      echo_q      <= side_q[DEPTH-1].tap;
      err_q       <= side_q[DEPTH-1].err;
    end
  end

  hwsf_sine u_sinc_sine (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_q),
    .value_o (sin_a)
  );

  hwsf_sine u_win_cos (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (cos_ph),
    .value_o (cos_v)
  );

  assign sc[0] = sinc_init_q;
  for (genvar k = 1; k <= SINC_STEPS; k++) begin : g_sinc_div
    hwsf_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (sc[k-1]),
      .div_o (sc[k])
    );
  end

  assign wc[0] = win_init_q;
  for (genvar k = 1; k <= WIN_STEPS; k++) begin : g_win_div
    hwsf_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (wc[k-1]),
      .div_o (wc[k])
    );
  end

  assign out_valid_o      = vld_q[DEPTH];
  assign coefficient_o    = $signed(coef_q);
  assign tap_index_echo_o = echo_q;
  assign index_error_o    = err_q;

endmodule
